// ===== design/lcm_pkg.sv =====
// Shared types and constants of the checkpoint latency monitor.
// No dependencies; imported by lcm_ctrl, lcm_dpath, the top level and the bench.
package lcm_pkg;

	localparam int TS_W  = 64;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;
	localparam int ST_W  = 3;

	localparam int MAX_POINTS = 64;
	localparam int RESULT_CAP = 64;

	// item modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_RTRIG = 2'd1;
	localparam logic [1:0] MODE_ADD   = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] STAT_OK      = 3'd0;
	localparam logic [ST_W-1:0] STAT_WRONG   = 3'd1;
	localparam logic [ST_W-1:0] STAT_PENDING = 3'd2;
	localparam logic [ST_W-1:0] STAT_FULL    = 3'd3;
	localparam logic [ST_W-1:0] STAT_DUMPED  = 3'd4;

	// configuration register indexes
	localparam logic REG_MAX_ENTRIES = 1'b0;
	localparam logic REG_OVERTIME    = 1'b1;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] entry_index;
		logic [TS_W-1:0]  offset_ns;
		logic [TS_W-1:0]  elapsed_ns;
		logic [TS_W-1:0]  step_ns;
		logic [TS_W-1:0]  min_ns;
		logic [TS_W-1:0]  max_ns;
		logic [CNT_W-1:0] entry_count;
		logic             last;
	} result_t;

	typedef struct packed {
		logic exec;   // take the input word and process it
		logic rd;     // read the next stored entry for a dump
		logic emit;   // load the dumped entry into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;   // output register empty or being taken
		logic dump_go;    // the input word is a stop that dumps entries
		logic dump_last;  // current dump entry is the final one
	} dp_stat_t;

endpackage

// ===== design/latency_checkpoint_monitor_core.sv =====
// Checkpoint latency monitor, top level.
// Depends on lcm_pkg, lcm_ctrl, lcm_dpath (and lcm_ram through it).
//
// Input words arrive on s_* : s_tuser carries the mode (start, reset trigger,
// add checkpoint, stop), s_tdata the timestamp and the two command flags.
// Results leave on m_*: m_tuser is the status, m_tlast marks the final
// result of an input word, m_tdata the entry fields and session marks.
// Registers max_entries and overtime_ns are written on the cfg_* port; the user
// must write them only while the block is idle (the block does not enforce it).
//
// A result sits in the output register in the cycle after its input word is
// taken. Start, reset trigger, add and non-dumping stop give one result each
// and are taken one per cycle while m_tready stays high.
// A dumping stop occupies the block while it walks its entries: each entry
// takes a table read (S_RD) and then a load of the output register (S_EMIT).
// s_tready drops during a dump and whenever the output register is full and
// m_tready is low; a stalled result is held unchanged.
// Reset clears the session (unarmed, no trigger, no entries, min all ones,
// max zero) and loads max_entries 64 and overtime_ns all ones. The entry
// table is not cleared; only entries written in the session are read.
module latency_checkpoint_monitor_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // now_ns[63:0], clear_trigger[64], force_dump[65]
	input  logic [1:0]   s_tuser,   // mode[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [335:0] m_tdata,   // entry_index[5:0], offset_ns[69:6],
	                                // elapsed_ns[133:70], step_ns[197:134],
	                                // min_ns[261:198], max_ns[325:262],
	                                // entry_count[332:326]
	output logic [2:0]   m_tuser,   // status[2:0]
	output logic         m_tlast
);
	import lcm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	result_t   res;

	lcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lcm_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mode          (s_tuser),
		.now_ns        (s_tdata[63:0]),
		.clear_trigger (s_tdata[64]),
		.force_dump    (s_tdata[65]),
		.cmd           (cmd),
		.stat          (stat),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.res           (res)
	);

	assign m_tdata = {3'b000, res.entry_count, res.max_ns, res.min_ns, res.step_ns,
		res.elapsed_ns, res.offset_ns, res.entry_index};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule

// ===== design/lcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/lcm_ctrl.sv =====
// Controller of the checkpoint latency monitor: input acceptance and dump walk.
// Depends on lcm_pkg; drives command strobes into lcm_dpath.
module lcm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  lcm_pkg::dp_stat_t    stat,
	output lcm_pkg::ctrl_cmd_t   cmd
);
	import lcm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EMIT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE) && stat.out_free;

	always_comb begin
		cmd      = '0;
		cmd.exec = s_tready && s_tvalid;
		cmd.rd   = (state_q == S_RD);
		cmd.emit = (state_q == S_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.exec && stat.dump_go) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register frees up
					if (stat.out_free) begin
						state_q <= stat.dump_last ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/lcm_dpath.sv =====
// Datapath of the checkpoint latency monitor: session state, marks, entry
// table and output register. Depends on lcm_pkg and lcm_ram.
module lcm_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [63:0]          cfg_wdata,
	input  logic [1:0]           mode,
	input  logic [63:0]          now_ns,
	input  logic                 clear_trigger,
	input  logic                 force_dump,
	input  lcm_pkg::ctrl_cmd_t   cmd,
	output lcm_pkg::dp_stat_t    stat,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output lcm_pkg::result_t     res
);
	import lcm_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [CNT_W-1:0] max_entries_q;
	logic [TS_W-1:0]  overtime_q;
	logic             armed_q;
	logic             tripped_q;
	logic [CNT_W-1:0] count_q;
	logic [TS_W-1:0]  low_q;
	logic [TS_W-1:0]  high_q;
	logic [TS_W-1:0]  base_q;
	logic [TS_W-1:0]  last_off_q;
	logic [TS_W-1:0]  prev_q;
	logic [CNT_W-1:0] dump_i_q;
	logic [CNT_W-1:0] dump_n_q;
	logic             out_valid_q;
	result_t          res_q;

	logic             n_armed;
	logic             n_tripped;
	logic [CNT_W-1:0] n_count;
	logic [TS_W-1:0]  n_low;
	logic [TS_W-1:0]  n_high;
	logic [TS_W-1:0]  n_base;
	logic             add_wr;
	logic             dump_go;
	result_t          exec_res;
	result_t          dump_res;

	logic [TS_W-1:0]  off;
	logic [TS_W-1:0]  step;
	logic             full;
	logic [TS_W-1:0]  rdata;
	logic [TS_W-1:0]  dstep;

	assign off  = now_ns - base_q;
	assign step = off - last_off_q;
	assign full = (32'(count_q) >= 32'(max_entries_q)) || (32'(count_q) >= MAX_POINTS);

	always_comb begin
		n_armed   = armed_q;
		n_tripped = tripped_q;
		n_count   = count_q;
		n_low     = low_q;
		n_high    = high_q;
		n_base    = base_q;
		add_wr    = 1'b0;
		dump_go   = 1'b0;
		exec_res  = '0;
		exec_res.last   = 1'b1;
		exec_res.status = STAT_OK;
		unique case (mode)
			MODE_START: begin
				if (armed_q) begin
					exec_res.status = STAT_WRONG;
				end else if (tripped_q && !clear_trigger) begin
					exec_res.status = STAT_PENDING;
				end else begin
					n_tripped = 1'b0;
					n_count   = '0;
					n_armed   = 1'b1;
					n_low     = '1;
					n_high    = '0;
					n_base    = now_ns;
				end
			end
			MODE_RTRIG: begin
				if (!armed_q) begin
					exec_res.status = STAT_WRONG;
				end else begin
					n_tripped = 1'b0;
					n_base    = now_ns;
				end
			end
			MODE_ADD: begin
				if (!armed_q) begin
					exec_res.status = STAT_WRONG;
				end else if (full) begin
					exec_res.status = STAT_FULL;
				end else begin
					add_wr = 1'b1;
					exec_res.entry_index = count_q[IDX_W-1:0];
					exec_res.offset_ns   = off;
					if (count_q != '0) begin
						exec_res.elapsed_ns = off;
						exec_res.step_ns    = step;
						if (off > high_q) begin
							n_high = off;
						end
						if (off < low_q) begin
							n_low = off;
						end
						if (off > overtime_q) begin
							n_tripped = 1'b1;
						end
					end
					n_count = count_q + 1'b1;
				end
			end
			MODE_STOP: begin
				if (!armed_q && !force_dump) begin
					exec_res.status = STAT_WRONG;
				end else begin
					n_armed = 1'b0;
					if (tripped_q || force_dump) begin
						exec_res.status = STAT_DUMPED;
						dump_go = (count_q != '0);
					end
				end
			end
			default: begin
				exec_res.status = STAT_WRONG;
			end
		endcase
		exec_res.min_ns      = n_low;
		exec_res.max_ns      = n_high;
		exec_res.entry_count = n_count;
	end

	// dumped entry: elapsed equals offset except for the first entry
	assign dstep = rdata - prev_q;

	always_comb begin
		dump_res             = '0;
		dump_res.status      = STAT_DUMPED;
		dump_res.entry_index = dump_i_q[IDX_W-1:0];
		dump_res.offset_ns   = rdata;
		if (dump_i_q != '0) begin
			dump_res.elapsed_ns = rdata;
			dump_res.step_ns    = dstep;
		end
		dump_res.min_ns      = low_q;
		dump_res.max_ns      = high_q;
		dump_res.entry_count = count_q;
		dump_res.last        = stat.dump_last;
	end

	assign stat.out_free  = !out_valid_q || m_tready;
	assign stat.dump_go   = dump_go;
	assign stat.dump_last = ((dump_i_q + 1'b1) == dump_n_q);

	lcm_ram #(
		.WIDTH (TS_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.exec && add_wr),
		.waddr (AW'(count_q)),
		.wdata (off),
		.re    (cmd.rd),
		.raddr (AW'(dump_i_q)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 7'd64;
			overtime_q    <= '1;
			armed_q       <= 1'b0;
			tripped_q     <= 1'b0;
			count_q       <= '0;
			low_q         <= '1;
			high_q        <= '0;
			base_q        <= '0;
			dump_i_q      <= '0;
			dump_n_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_ENTRIES: max_entries_q <= cfg_wdata[CNT_W-1:0];
					REG_OVERTIME:    overtime_q    <= cfg_wdata;
					default:         ;
				endcase
			end
			if (cmd.exec) begin
				armed_q   <= n_armed;
				tripped_q <= n_tripped;
				count_q   <= n_count;
				low_q     <= n_low;
				high_q    <= n_high;
				base_q    <= n_base;
				if (dump_go) begin
					dump_i_q <= '0;
					dump_n_q <= (32'(count_q) > RESULT_CAP) ? CNT_W'(RESULT_CAP) : count_q;
				end
			end
			if (cmd.emit) begin
				dump_i_q <= dump_i_q + 1'b1;
			end
			if ((cmd.exec && !dump_go) || cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && add_wr) begin
			last_off_q <= off;
		end
		if (cmd.emit) begin
			prev_q <= rdata;
			res_q  <= dump_res;
		end else if (cmd.exec && !dump_go) begin
			res_q <= exec_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

	a_dump_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && dump_go) |=> (!armed_q && dump_i_q == '0))
		else $error("dump start did not disarm or reset the walk");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (dump_i_q < dump_n_q))
		else $error("dump walked past the stored entries");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && res_q.status == STAT_DUMPED))
		else $error("dumped entry not presented");

endmodule

// ===== bench/latency_checkpoint_monitor_core_tb.sv =====
// Self-checking bench for latency_checkpoint_monitor_core: directed words, then random sessions.
// Uses lcm_pkg for modes, status codes and register indexes.
// A session tracker class predicts the results and compares them with the DUT outputs.
module latency_checkpoint_monitor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcm_pkg::*;

	localparam int LIMIT_CYCLES = 500_000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 50;
	localparam int RANDOM_WORDS = 208;
	localparam int PHASES       = 8;

	typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_pace_e;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic         cfg_index = REG_MAX_ENTRIES;
	logic [63:0]  cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata   = '0;   // now_ns[63:0], clear_trigger[64], force_dump[65]
	logic [1:0]   s_tuser   = MODE_START;   // mode[1:0]
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [335:0] m_tdata;   // entry_index[5:0], offset_ns[69:6], elapsed_ns[133:70],
	                         // step_ns[197:134], min_ns[261:198], max_ns[325:262],
	                         // entry_count[332:326]
	logic [2:0]   m_tuser;   // status[2:0]
	logic         m_tlast;

	latency_checkpoint_monitor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	class checkpoint_tracker;
		logic [CNT_W-1:0] max_entries;
		logic [TS_W-1:0]  overtime_ns;
		bit               armed;
		bit               tripped;
		logic [CNT_W-1:0] stored;
		logic [TS_W-1:0]  low_mark;
		logic [TS_W-1:0]  high_mark;
		logic [TS_W-1:0]  base_time;
		logic [TS_W-1:0]  entry_offsets [MAX_POINTS];
		result_t          pending_results [$];
		int               fails;

		function new();
			max_entries = 7'd64;
			overtime_ns = '1;
			armed       = 1'b0;
			tripped     = 1'b0;
			stored      = '0;
			low_mark    = '1;
			high_mark   = '0;
			base_time   = '0;
			fails       = 0;
			foreach (entry_offsets[i])
				entry_offsets[i] = '0;
		endfunction

		function void set_registers(logic [CNT_W-1:0] max_e, logic [TS_W-1:0] over);
			max_entries = max_e;
			overtime_ns = over;
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		function void queue_result(logic [ST_W-1:0] status, logic [IDX_W-1:0] idx,
				logic [TS_W-1:0] off, logic [TS_W-1:0] el, logic [TS_W-1:0] st, bit last);
			result_t r;
			r.status      = status;
			r.entry_index = idx;
			r.offset_ns   = off;
			r.elapsed_ns  = el;
			r.step_ns     = st;
			r.min_ns      = low_mark;
			r.max_ns      = high_mark;
			r.entry_count = stored;
			r.last        = last;
			pending_results.push_back(r);
		endfunction

		// advance the session state by one accepted word and queue what it produces
		function void take_word(logic [1:0] mode, logic [TS_W-1:0] now, logic clr,
				logic force_dump);
			int unsigned lim;
			int unsigned n;
			int unsigned idx;
			logic [TS_W-1:0] off;
			logic [TS_W-1:0] el;
			logic [TS_W-1:0] st;
			case (mode)
				MODE_START: begin
					if (armed) begin
						queue_result(STAT_WRONG, '0, '0, '0, '0, 1'b1);
					end else begin
						if (clr)
							tripped = 1'b0;
						if (tripped) begin
							queue_result(STAT_PENDING, '0, '0, '0, '0, 1'b1);
						end else begin
							stored    = '0;
							armed     = 1'b1;
							low_mark  = '1;
							high_mark = '0;
							base_time = now;
							queue_result(STAT_OK, '0, '0, '0, '0, 1'b1);
						end
					end
				end
				MODE_RTRIG: begin
					if (!armed) begin
						queue_result(STAT_WRONG, '0, '0, '0, '0, 1'b1);
					end else begin
						tripped   = 1'b0;
						base_time = now;
						queue_result(STAT_OK, '0, '0, '0, '0, 1'b1);
					end
				end
				MODE_ADD: begin
					lim = (32'(max_entries) < MAX_POINTS) ? 32'(max_entries) : MAX_POINTS;
					idx = 32'(stored);
					if (!armed) begin
						queue_result(STAT_WRONG, '0, '0, '0, '0, 1'b1);
					end else if (idx >= lim) begin
						queue_result(STAT_FULL, '0, '0, '0, '0, 1'b1);
					end else begin
						off = now - base_time;
						el  = '0;
						st  = '0;
						if (idx != 0) begin
							el = off;
							if (el > high_mark)
								high_mark = el;
							if (el < low_mark)
								low_mark = el;
							if (el > overtime_ns)
								tripped = 1'b1;
							st = off - entry_offsets[idx-1];
						end
						entry_offsets[idx] = off;
						stored = CNT_W'(idx + 1);
						queue_result(STAT_OK, idx[IDX_W-1:0], off, el, st, 1'b1);
					end
				end
				default: begin
					if (!armed && !force_dump) begin
						queue_result(STAT_WRONG, '0, '0, '0, '0, 1'b1);
					end else begin
						armed = 1'b0;
						if (!tripped && !force_dump) begin
							queue_result(STAT_OK, '0, '0, '0, '0, 1'b1);
						end else begin
							n = 32'(stored);
							if (n > MAX_POINTS)
								n = MAX_POINTS;
							if (n > RESULT_CAP)
								n = RESULT_CAP;
							if (n == 0)
								queue_result(STAT_DUMPED, '0, '0, '0, '0, 1'b1);
							for (int unsigned i = 0; i < n; i++) begin
								off = entry_offsets[i];
								el  = (i != 0) ? off : '0;
								st  = (i != 0) ? off - entry_offsets[i-1] : '0;
								queue_result(STAT_DUMPED, i[IDX_W-1:0], off, el, st, i + 1 == n);
							end
						end
					end
				end
			endcase
		endfunction

		task report(string what);
			if (fails < 30)
				$display("mismatch: %s", what);
			fails++;
		endtask

		task match_result(logic [ST_W-1:0] status, logic [335:0] data, logic last);
			result_t want;
			if (pending_results.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			if (status !== want.status)
				report($sformatf("status %0d, want %0d", status, want.status));
			if (data[5:0] !== want.entry_index)
				report($sformatf("entry_index %0d, want %0d", data[5:0], want.entry_index));
			if (data[69:6] !== want.offset_ns)
				report($sformatf("offset_ns %h, want %h", data[69:6], want.offset_ns));
			if (data[133:70] !== want.elapsed_ns)
				report($sformatf("elapsed_ns %h, want %h", data[133:70], want.elapsed_ns));
			if (data[197:134] !== want.step_ns)
				report($sformatf("step_ns %h, want %h", data[197:134], want.step_ns));
			if (data[261:198] !== want.min_ns)
				report($sformatf("min_ns %h, want %h", data[261:198], want.min_ns));
			if (data[325:262] !== want.max_ns)
				report($sformatf("max_ns %h, want %h", data[325:262], want.max_ns));
			if (data[332:326] !== want.entry_count)
				report($sformatf("entry_count %0d, want %0d", data[332:326], want.entry_count));
			if (last !== want.last)
				report($sformatf("tlast %b, want %b", last, want.last));
		endtask

		task finish_check();
			if (pending_results.size() != 0)
				report($sformatf("%0d result words never arrived", pending_results.size()));
		endtask
	endclass

	checkpoint_tracker tracker = new();

	int       burst_left    = 0;
	int       words_sent    = 0;
	int       hold_requests = 0;
	int       holds_started = 0;
	int       hold_left     = 0;
	int       pace_left     = 0;
	rx_pace_e pace          = RX_OPEN;
	int       cycles        = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: changing pace, plus a long hold when the stimulus asks for one
	always @(posedge clk) begin
		if (hold_requests != holds_started) begin
			holds_started = hold_requests;
			hold_left     = LONG_HOLD;
		end
		if (pace_left == 0) begin
			pace      = rx_pace_e'($urandom_range(0, 3));
			pace_left = $urandom_range(20, 120);
		end else begin
			pace_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (pace)
				RX_OPEN:   m_tready <= 1'b1;
				RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ~m_tready;
			endcase
		end
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			tracker.match_result(m_tuser, m_tdata, m_tlast);
	end

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// present one word, with a random gap between bursts, and hold until it is taken
	task automatic send_word(logic [1:0] mode, logic [63:0] now, logic clr, logic force_dump);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, force_dump, clr, now};
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.take_word(mode, now, clr, force_dump);
		words_sent++;
	endtask

	task automatic go_idle();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [CNT_W-1:0] max_e, logic [63:0] over);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_ENTRIES;
		cfg_wdata <= {57'd0, max_e};
		@(posedge clk);
		cfg_index <= REG_OVERTIME;
		cfg_wdata <= over;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_registers(max_e, over);
	endtask

	// a well-formed session with random timing; some trip, some overflow the table
	task automatic run_session();
		logic [63:0] t;
		int n_adds;
		t = ($urandom_range(0, 3) == 0) ? rand64() : {32'd0, $urandom};
		send_word(MODE_START, t, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
		n_adds = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 66) : $urandom_range(0, 8);
		for (int i = 0; i < n_adds; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_word(MODE_RTRIG, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			t = ($urandom_range(0, 15) == 0) ? rand64() : t + $urandom_range(0, 700);
			send_word(MODE_ADD, t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		send_word(MODE_STOP, t + $urandom_range(0, 50), 1'($urandom_range(0, 1)),
			$urandom_range(0, 2) == 0);
	endtask

	initial begin
		logic [63:0] t0;
		logic [CNT_W-1:0] max_e;
		logic [63:0] over;
		int phase_end;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unarmed refusals and an empty forced dump, then wrapping offsets
		send_word(MODE_ADD, 64'd7, 1'b1, 1'b1);
		send_word(MODE_RTRIG, 64'd7, 1'b0, 1'b0);
		send_word(MODE_STOP, 64'd0, 1'b0, 1'b0);
		send_word(MODE_STOP, '1, 1'b1, 1'b1);
		send_word(MODE_START, 64'd0, 1'b0, 1'b0);
		send_word(MODE_START, 64'd9, 1'b1, 1'b0);
		send_word(MODE_ADD, 64'd0, 1'b0, 1'b0);
		send_word(MODE_ADD, '1, 1'b0, 1'b0);
		send_word(MODE_ADD, 64'd5, 1'b0, 1'b0);
		send_word(MODE_RTRIG, 64'd3, 1'b0, 1'b0);
		send_word(MODE_ADD, 64'd2, 1'b0, 1'b0);
		send_word(MODE_STOP, 64'd4, 1'b0, 1'b0);
		go_idle();

		// trip on the third entry, overflow a three-entry table, dump it
		set_config(7'd3, 64'd100);
		t0 = 64'hFFFF_FFFF_FFFF_FFF0;
		send_word(MODE_START, t0, 1'b1, 1'b0);
		send_word(MODE_ADD, t0 + 64'd10, 1'b0, 1'b0);
		send_word(MODE_ADD, t0 + 64'd50, 1'b0, 1'b0);
		send_word(MODE_ADD, t0 + 64'd200, 1'b0, 1'b0);
		send_word(MODE_ADD, t0 + 64'd300, 1'b0, 1'b0);
		send_word(MODE_START, t0, 1'b1, 1'b0);
		send_word(MODE_STOP, t0 + 64'd400, 1'b0, 1'b0);
		send_word(MODE_START, 64'd1, 1'b0, 1'b0);
		send_word(MODE_START, 64'd1, 1'b1, 1'b0);
		send_word(MODE_STOP, 64'd2, 1'b0, 1'b1);
		go_idle();

		set_config(7'd0, 64'd0);
		send_word(MODE_START, 64'd10, 1'b0, 1'b0);
		send_word(MODE_ADD, 64'd11, 1'b0, 1'b0);
		send_word(MODE_STOP, 64'd12, 1'b0, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			go_idle();
			if (ph == 0) begin
				max_e = 7'd64;
				over  = 64'($urandom_range(200, 2000));
			end else if (ph == 1) begin
				max_e = 7'd1;
				over  = '1;
			end else begin
				case ($urandom_range(0, 4))
					0:       max_e = 7'd0;
					1:       max_e = 7'd1;
					2:       max_e = 7'd64;
					default: max_e = CNT_W'($urandom_range(1, 64));
				endcase
				case ($urandom_range(0, 3))
					0:       over = '1;
					1:       over = '0;
					2:       over = 64'($urandom_range(0, 3000));
					default: over = rand64();
				endcase
			end
			set_config(max_e, over);
			// stall the receiver while the sender keeps pushing
			if (ph == 2)
				hold_requests++;
			phase_end = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0)
					send_word(2'($urandom_range(0, 3)), rand64(), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					run_session();
			end
		end

		s_tvalid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		tracker.finish_check();
		if (tracker.fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
design/lcm_pkg.sv
design/lcm_ram.sv
design/lcm_ctrl.sv
design/lcm_dpath.sv
design/latency_checkpoint_monitor_core.sv
bench/latency_checkpoint_monitor_core_tb.sv
